// ----- sv/lj_pkg.sv -----
// ----------------------------------------------------------------------------
// lj_pkg
// Shared types and constants for the Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
package lj_pkg;

  // Clip level for every wide intermediate value
  localparam logic [63:0] CAP          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP_DIV2     = CAP / 64'd2;
  localparam logic [63:0] CAP_DIV4     = CAP / 64'd4;
  localparam logic [63:0] CAP_DIV24    = CAP / 64'd24;
  localparam logic [63:0] ENERGY_LIMIT = 64'h0000_0100_0000_0000;

  // Register reset values
  localparam logic [31:0] SIGMA_SQ_RST     = 32'h0001_0000;
  localparam logic [31:0] WELL_DEPTH_RST   = 32'h0001_0000;
  localparam logic [31:0] CUTOFF_SQ_RST    = 32'hFFFF_FFFF;
  localparam logic [31:0] ENERGY_SHIFT_RST = 32'h0000_0000;

  typedef enum logic [1:0] {
    REG_SIGMA_SQ     = 2'd0,
    REG_WELL_DEPTH   = 2'd1,
    REG_CUTOFF_SQ    = 2'd2,
    REG_ENERGY_SHIFT = 2'd3
  } reg_idx_t;

  // Geometry of one pair, carried alongside the arithmetic
  typedef struct packed {
    logic [2:0][32:0] mag;      // |d| per axis
    logic [2:0]       dneg;     // sign of d per axis
    logic             outside;  // R2 above cutoff
    logic             zero;     // coincident particles
    logic [31:0]      r2;       // squared distance, never zero
  } geo_t;

  // One result item
  typedef struct packed {
    logic [31:0] pair_energy;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic        inside_cutoff;
    logic        saturated;
    logic        zero_distance;
  } res_t;

endpackage

// ----- sv/lj_stream_if.sv -----
// ----------------------------------------------------------------------------
// lj_in_if / lj_out_if
// Valid/ready channels for particle pairs and pair results.
// ----------------------------------------------------------------------------
interface lj_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

interface lj_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pair_energy;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic               inside_cutoff;
  logic               saturated;
  logic               zero_distance;

  modport source (output valid, pair_energy, force_x, force_y, force_z, inside_cutoff,
                  saturated, zero_distance, input ready);
  modport sink (input valid, pair_energy, force_x, force_y, force_z, inside_cutoff,
                saturated, zero_distance, output ready);
endinterface

// ----- sv/lj_delay.sv -----
// ----------------------------------------------------------------------------
// lj_delay
// Stall-aware delay line with a valid bit per stage.
// ----------------------------------------------------------------------------
module lj_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [N-1:0]        v_r;
  logic [N-1:0][W-1:0] d_r;

  for (genvar i = 0; i < N; i++) begin : g_stg
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= vin;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[i] <= din;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= v_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[i] <= d_r[i-1];
        end
      end
    end
  end

  assign vout = v_r[N-1];
  assign dout = d_r[N-1];

endmodule

// ----- sv/lj_div.sv -----
// ----------------------------------------------------------------------------
// lj_div
// Pipelined restoring divider, one quotient bit per stage.
// Needs rem_in < den_in; the quotient is registered in the last stage.
// ----------------------------------------------------------------------------
module lj_div #(
  parameter int QW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  output logic [QW-1:0] quo
);

  logic [QW-1:0][DW-1:0] rem_r;
  logic [QW-1:0][QW-1:0] nq_r;    // numerator bits left, quotient bits shifted in
  logic [QW-1:0][DW-1:0] den_r;

  for (genvar i = 0; i < QW; i++) begin : g_stg
    logic [DW-1:0] rem_s;
    logic [QW-1:0] nq_s;
    logic [DW-1:0] den_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_src0
      assign rem_s = rem_in;
      assign nq_s  = num_in;
      assign den_s = den_in;
    end else begin : g_srcn
      assign rem_s = rem_r[i-1];
      assign nq_s  = nq_r[i-1];
      assign den_s = den_r[i-1];
    end

    assign trial = {rem_s, nq_s[QW-1]};
    assign diff  = trial - {1'b0, den_s};
    assign ge    = (trial >= {1'b0, den_s});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[i]  <= {nq_s[QW-2:0], ge};
        den_r[i] <= den_s;
      end
    end
  end

  assign quo = nq_r[QW-1];

endmodule

// ----- sv/lj_mulq.sv -----
// ----------------------------------------------------------------------------
// lj_mulq
// Fixed-point product floor(a*b / 2^F) clipped at CAP, two stages:
// 32x32 partial products, then sum, scale and clip.
// ----------------------------------------------------------------------------
module lj_mulq
  import lj_pkg::*;
#(
  parameter int F = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        sat
);

  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] full;
  logic         sat_nxt;
  logic [63:0]  p_nxt;
  logic [63:0]  p_r;
  logic         sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= a[31:0]  * b[31:0];
      p01_r <= a[31:0]  * b[63:32];
      p10_r <= a[63:32] * b[31:0];
      p11_r <= a[63:32] * b[63:32];
    end
  end

  always_comb begin
    full    = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
            + {p11_r, 64'd0};
    sat_nxt = |full[127:63+F];
    p_nxt   = sat_nxt ? CAP : {1'b0, full[62+F:F]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

// ----- sv/lj_pair_force_truncated_core.sv -----
// ----------------------------------------------------------------------------
// lj_pair_force_truncated_core
// Depth: 82 + FRACTION_BITS register stages (98 at 16), output register included.
// Throughput: one pair per cycle while the skid register is empty, set by the fully
// pipelined dividers and multipliers. A stalled output parks one result in the skid
// register; while it is full the whole pipe freezes and intake is held off.
// rst_n (synchronous, low) clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module lj_pair_force_truncated_core
  import lj_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lj_in_if.sink       in_bus,
  lj_out_if.source    out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F  = FRACTION_BITS;
  localparam int QW = 32 + F;          // x2 quotient width
  localparam int GW = $bits(geo_t);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] sigma_r, well_r, cutoff_r, shift_r;
  reg_idx_t    cfg_idx;

  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r  <= SIGMA_SQ_RST;
      well_r   <= WELL_DEPTH_RST;
      cutoff_r <= CUTOFF_SQ_RST;
      shift_r  <= ENERGY_SHIFT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_SIGMA_SQ:     sigma_r  <= pwdata;
        REG_WELL_DEPTH:   well_r   <= pwdata;
        REG_CUTOFF_SQ:    cutoff_r <= pwdata;
        REG_ENERGY_SHIFT: shift_r  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIGMA_SQ:     prdata = sigma_r;
      REG_WELL_DEPTH:   prdata = well_r;
      REG_CUTOFF_SQ:    prdata = cutoff_r;
      REG_ENERGY_SHIFT: prdata = shift_r;
    endcase
  end

  // --------------------------------------------------------------------------
  // Global advance: the whole pipeline moves unless the skid register is full
  // --------------------------------------------------------------------------
  logic skid_v_r;
  logic adv;

  assign adv          = !skid_v_r;
  assign in_bus.ready = adv;

  // --------------------------------------------------------------------------
  // S1: separation d = first - second, exact 33 bits
  // --------------------------------------------------------------------------
  logic             v1_r;
  logic [2:0][32:0] d1_r, d1_nxt;

  always_comb begin
    d1_nxt[0] = {in_bus.first_x[31], in_bus.first_x} - {in_bus.second_x[31], in_bus.second_x};
    d1_nxt[1] = {in_bus.first_y[31], in_bus.first_y} - {in_bus.second_y[31], in_bus.second_y};
    d1_nxt[2] = {in_bus.first_z[31], in_bus.first_z} - {in_bus.second_z[31], in_bus.second_z};
  end

  // S2: magnitude and sign
  logic             v2_r;
  logic [2:0][32:0] mag2_r, mag2_nxt;
  logic [2:0]       neg2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag2_nxt[i] = d1_r[i][32] ? 33'(-d1_r[i]) : d1_r[i];
    end
  end

  // S3: squares (|d| <= 2^32, so the square fits 65 bits)
  logic             v3_r;
  logic [2:0][64:0] sq3_r, sq3_nxt;
  logic [2:0][32:0] mag3_r;
  logic [2:0]       neg3_r;
  logic [65:0]      sq_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = mag2_r[i] * mag2_r[i];
      sq3_nxt[i] = sq_full[i][64:0];
    end
  end

  // S4: sum of squares
  logic             v4_r;
  logic [66:0]      sum4_r, sum4_nxt;
  logic [2:0][32:0] mag4_r;
  logic [2:0]       neg4_r;

  assign sum4_nxt = 67'(sq3_r[0]) + 67'(sq3_r[1]) + 67'(sq3_r[2]);

  // S5: R2, cutoff test, coincidence test
  logic        v5_r;
  geo_t        geo5_r, geo5_nxt;
  logic [66-F:0] r2_full;

  always_comb begin
    r2_full          = sum4_r[66:F];
    geo5_nxt.mag     = mag4_r;
    geo5_nxt.dneg    = neg4_r;
    geo5_nxt.outside = (r2_full > {{(35-F){1'b0}}, cutoff_r});
    geo5_nxt.zero    = (mag4_r[0] == '0) && (mag4_r[1] == '0) && (mag4_r[2] == '0);
    // a nonzero separation whose R2 rounds away counts as one LSB
    geo5_nxt.r2      = (r2_full[31:0] == '0) ? 32'd1 : r2_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_bus.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r   <= d1_nxt;
      mag2_r <= mag2_nxt;
      for (int i = 0; i < 3; i++) begin
        neg2_r[i] <= d1_r[i][32];
      end
      sq3_r  <= sq3_nxt;
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
      sum4_r <= sum4_nxt;
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
      geo5_r <= geo5_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // x2 = sigma^2 * 2^F / R2 (QW pipelined divide steps)
  // --------------------------------------------------------------------------
  logic [QW-1:0] x2_q;
  logic [63:0]   x2_6;
  logic          v6;
  geo_t          geo6;

  lj_div #(.QW(QW), .DW(32)) u_div_x2 (
    .clk    (clk),
    .en     (adv),
    .rem_in (32'd0),
    .num_in ({sigma_r, {F{1'b0}}}),
    .den_in (geo5_r.r2),
    .quo    (x2_q)
  );

  lj_delay #(.W(GW), .N(QW)) u_dly_div (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .vin (v5_r), .din (geo5_r),
    .vout (v6), .dout (geo6)
  );

  assign x2_6 = {{(64-QW){1'b0}}, x2_q};

  // --------------------------------------------------------------------------
  // x6 = (x2*x2)*x2, x12 = x6*x6, each product two stages
  // --------------------------------------------------------------------------
  logic [63:0] x2sq, x6, x12;
  logic        sat_a, sat_b, sat_c;
  logic        v7, v8, v9;
  geo_t        geo7, geo8, geo9;
  logic [63:0] x2_7, x6_9;
  logic        sat8, sat9;

  lj_mulq #(.F(F)) u_mul_x2sq (
    .clk (clk), .en (adv), .a (x2_6), .b (x2_6), .p (x2sq), .sat (sat_a)
  );

  lj_delay #(.W(GW + 64), .N(2)) u_dly_m1 (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .vin (v6), .din ({geo6, x2_6}),
    .vout (v7), .dout ({geo7, x2_7})
  );

  lj_mulq #(.F(F)) u_mul_x6 (
    .clk (clk), .en (adv), .a (x2sq), .b (x2_7), .p (x6), .sat (sat_b)
  );

  lj_delay #(.W(GW + 1), .N(2)) u_dly_m2 (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .vin (v7), .din ({geo7, sat_a}),
    .vout (v8), .dout ({geo8, sat8})
  );

  lj_mulq #(.F(F)) u_mul_x12 (
    .clk (clk), .en (adv), .a (x6), .b (x6), .p (x12), .sat (sat_c)
  );

  lj_delay #(.W(GW + 65), .N(2)) u_dly_m3 (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .vin (v8), .din ({geo8, sat8 | sat_b, x6}),
    .vout (v9), .dout ({geo9, sat9, x6_9})
  );

  // --------------------------------------------------------------------------
  // S10: |x12 - x6| for energy, |2*x12 - x6| for force, with their signs
  // --------------------------------------------------------------------------
  logic        v10_r;
  geo_t        geo10_r;
  logic [63:0] diff10_r, diff10_nxt, g10_r, g10_nxt, t10;
  logic        eneg10_r, eneg10_nxt, gneg10_r, gneg10_nxt;
  logic        sat10_r, sat10_nxt, tsat;

  always_comb begin
    eneg10_nxt = (x12 < x6_9);
    diff10_nxt = eneg10_nxt ? (x6_9 - x12) : (x12 - x6_9);
    tsat       = (x12 > CAP_DIV2);
    t10        = tsat ? CAP : {x12[62:0], 1'b0};
    gneg10_nxt = (t10 < x6_9);
    g10_nxt    = gneg10_nxt ? (x6_9 - t10) : (t10 - x6_9);
    sat10_nxt  = sat9 | sat_c | tsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (adv) begin
      v10_r <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo10_r  <= geo9;
      diff10_r <= diff10_nxt;
      g10_r    <= g10_nxt;
      eneg10_r <= eneg10_nxt;
      gneg10_r <= gneg10_nxt;
      sat10_r  <= sat10_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // eps * diff and eps * g
  // --------------------------------------------------------------------------
  logic [63:0] ew, mw;
  logic        sat_d, sat_e;
  logic        v11;
  geo_t        geo11;
  logic        eneg11, gneg11, sat11;

  lj_mulq #(.F(F)) u_mul_e (
    .clk (clk), .en (adv), .a ({32'd0, well_r}), .b (diff10_r), .p (ew), .sat (sat_d)
  );

  lj_mulq #(.F(F)) u_mul_g (
    .clk (clk), .en (adv), .a ({32'd0, well_r}), .b (g10_r), .p (mw), .sat (sat_e)
  );

  lj_delay #(.W(GW + 3), .N(2)) u_dly_m4 (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .vin (v10_r), .din ({geo10_r, eneg10_r, gneg10_r, sat10_r}),
    .vout (v11), .dout ({geo11, eneg11, gneg11, sat11})
  );

  // --------------------------------------------------------------------------
  // S12: e = 4*eps*diff clipped at 2^40, m = 24*eps*g
  // --------------------------------------------------------------------------
  logic        v12_r;
  geo_t        geo12_r;
  logic [40:0] e12_r, e12_nxt;
  logic [63:0] m12_r, m12_nxt, e4;
  logic        eneg12_r, gneg12_r, sat12_r, sat12_nxt, e4sat, m24sat;

  always_comb begin
    e4sat     = (ew > CAP_DIV4);
    e4        = e4sat ? CAP : {ew[61:0], 2'b00};
    e12_nxt   = (e4 > ENERGY_LIMIT) ? ENERGY_LIMIT[40:0] : e4[40:0];
    m24sat    = (mw > CAP_DIV24);
    m12_nxt   = m24sat ? CAP : 64'(mw * 64'd24);
    sat12_nxt = sat11 | sat_d | sat_e | e4sat | m24sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else if (adv) begin
      v12_r <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo12_r  <= geo11;
      e12_r    <= e12_nxt;
      m12_r    <= m12_nxt;
      eneg12_r <= eneg11;
      gneg12_r <= gneg11;
      sat12_r  <= sat12_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // S13: energy with shift and clip; partial products |d_i| * m
  // --------------------------------------------------------------------------
  logic               v13_r;
  logic               outside13_r, zero13_r;
  logic [31:0]        r2_13_r;
  logic [31:0]        energy13_r, energy13_nxt;
  logic               sat13_r, sat13_nxt;
  logic [2:0][64:0]   plo13_r, plo13_nxt;
  logic [2:0][63:0]   phi13_r, phi13_nxt;
  logic [2:0]         fneg13_r, fneg13_nxt;
  logic signed [42:0] e_s, sh_s, en_s;
  logic               esat;

  always_comb begin
    e_s  = eneg12_r ? -$signed({2'b00, e12_r}) : $signed({2'b00, e12_r});
    sh_s = $signed({{11{shift_r[31]}}, shift_r});
    en_s = e_s - sh_s;
    esat = 1'b1;
    if (en_s > 43'sd2147483647) begin
      energy13_nxt = 32'h7FFF_FFFF;
    end else if (en_s < -43'sd2147483648) begin
      energy13_nxt = 32'h8000_0000;
    end else begin
      energy13_nxt = en_s[31:0];
      esat         = 1'b0;
    end
    sat13_nxt = sat12_r | esat;
    for (int i = 0; i < 3; i++) begin
      plo13_nxt[i]  = geo12_r.mag[i] * m12_r[31:0];
      phi13_nxt[i]  = geo12_r.mag[i] * m12_r[62:32];
      fneg13_nxt[i] = (geo12_r.dneg[i] != gneg12_r) && (geo12_r.mag[i] != '0)
                    && (m12_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
    end else if (adv) begin
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outside13_r <= geo12_r.outside;
      zero13_r    <= geo12_r.zero;
      r2_13_r     <= geo12_r.r2;
      energy13_r  <= energy13_nxt;
      sat13_r     <= sat13_nxt;
      plo13_r     <= plo13_nxt;
      phi13_r     <= phi13_nxt;
      fneg13_r    <= fneg13_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // S14: full 96-bit products
  // --------------------------------------------------------------------------
  logic             v14_r;
  logic             outside14_r, zero14_r, sat14_r;
  logic [31:0]      r2_14_r, energy14_r;
  logic [2:0]       fneg14_r;
  logic [2:0][95:0] p14_r, p14_nxt;
  logic [2:0]       hsat14;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p14_nxt[i] = {31'd0, plo13_r[i]} + {phi13_r[i], 32'd0};
      // quotient would reach 2^32: certain clip, divider result unused
      hsat14[i]  = (p14_r[i][95:32] >= {32'd0, r2_14_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v14_r <= 1'b0;
    end else if (adv) begin
      v14_r <= v13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outside14_r <= outside13_r;
      zero14_r    <= zero13_r;
      sat14_r     <= sat13_r;
      r2_14_r     <= r2_13_r;
      energy14_r  <= energy13_r;
      fneg14_r    <= fneg13_r;
      p14_r       <= p14_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Force quotients P / R2, 32 steps each
  // --------------------------------------------------------------------------
  logic [2:0][31:0] fq;
  logic             v15;
  logic [31:0]      energy15;
  logic             sat15, outside15, zero15;
  logic [2:0]       fneg15, hsat15;

  for (genvar i = 0; i < 3; i++) begin : g_fdiv
    lj_div #(.QW(32), .DW(32)) u_div_f (
      .clk    (clk),
      .en     (adv),
      .rem_in (p14_r[i][63:32]),
      .num_in (p14_r[i][31:0]),
      .den_in (r2_14_r),
      .quo    (fq[i])
    );
  end

  lj_delay #(.W(41), .N(32)) u_dly_f (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .vin (v14_r),
    .din ({energy14_r, sat14_r, outside14_r, zero14_r, fneg14_r, hsat14}),
    .vout (v15),
    .dout ({energy15, sat15, outside15, zero15, fneg15, hsat15})
  );

  // --------------------------------------------------------------------------
  // Result assembly: force clip and sign, special cases
  // --------------------------------------------------------------------------
  res_t             res_nxt;
  logic [2:0][31:0] fval;
  logic [2:0]       fover;
  logic [31:0]      flim, fmag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      flim     = fneg15[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      fover[i] = hsat15[i] || (fq[i] > flim);
      fmag     = fover[i] ? flim : fq[i];
      fval[i]  = fneg15[i] ? 32'(-fmag) : fmag;
    end
    res_nxt = '0;
    if (!outside15) begin
      res_nxt.inside_cutoff = 1'b1;
      if (zero15) begin
        res_nxt.zero_distance = 1'b1;
      end else begin
        res_nxt.pair_energy = energy15;
        res_nxt.force_x     = fval[0];
        res_nxt.force_y     = fval[1];
        res_nxt.force_z     = fval[2];
        res_nxt.saturated   = sat15 | (|fover);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register plus skid register
  // --------------------------------------------------------------------------
  logic out_v_r;
  res_t out_r, skid_r;
  logic push;

  assign push = adv && v15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_bus.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_bus.ready || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (push) begin
      skid_r <= res_nxt;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.pair_energy   = out_r.pair_energy;
  assign out_bus.force_x       = out_r.force_x;
  assign out_bus.force_y       = out_r.force_y;
  assign out_bus.force_z       = out_r.force_z;
  assign out_bus.inside_cutoff = out_r.inside_cutoff;
  assign out_bus.saturated     = out_r.saturated;
  assign out_bus.zero_distance = out_r.zero_distance;

endmodule

// ----- sv/lj_chk.sv -----
// ----------------------------------------------------------------------------
// lj_chk
// Port-level checks on the pair force core, bound into lj_pair_force_truncated_core.
// ----------------------------------------------------------------------------
module lj_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pair_energy,
  input logic [31:0] force_x,
  input logic [31:0] force_y,
  input logic [31:0] force_z,
  input logic        inside_cutoff,
  input logic        saturated,
  input logic        zero_distance
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pair_energy) && $stable(force_x)
      && $stable(force_y) && $stable(force_z) && $stable(saturated))
    else $error("result changed while stalled");

  // beyond cutoff everything is zero
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !inside_cutoff |-> pair_energy == '0 && force_x == '0 && force_y == '0
      && force_z == '0 && !saturated && !zero_distance)
    else $error("nonzero result outside cutoff");

  // coincident particles: inside, no energy, no force, no clip
  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_distance |-> inside_cutoff && pair_energy == '0 && force_x == '0
      && force_y == '0 && force_z == '0 && !saturated)
    else $error("bad coincident-particle result");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lj_pair_force_truncated_core lj_chk u_lj_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .pair_energy   (out_bus.pair_energy),
  .force_x       (out_bus.force_x),
  .force_y       (out_bus.force_y),
  .force_z       (out_bus.force_z),
  .inside_cutoff (out_bus.inside_cutoff),
  .saturated     (out_bus.saturated),
  .zero_distance (out_bus.zero_distance)
);

// ----- test/lj_pair_force_truncated_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lj_pair_force_truncated_core_tb
// Self-checking bench: streams particle pairs through the LJ force pipeline,
// predicts each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module lj_pair_force_truncated_core_tb
  import lj_pkg::*;
();

  localparam int FB      = 16;
  localparam int LATENCY = 82 + FB;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  lj_in_if  in_bus ();
  lj_out_if out_bus ();

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lj_pair_force_truncated_core #(.FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the register file
  logic [31:0] sigma_sq, well_depth, cutoff_sq, shift;

  res_t expected_results[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;   // long receiver hold-off, counted down by the sink
  bit   sending = 1'b0;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.first_x = '0; in_bus.first_y = '0; in_bus.first_z = '0;
    in_bus.second_x = '0; in_bus.second_y = '0; in_bus.second_z = '0;
    out_bus.ready = 1'b0;
  end

  // ---------------------------------------------------------------- prediction
  // floor(a*b / 2^F), clipped at CAP
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, inout bit sat);
    logic [127:0] p;
    p = a * b;
    p = p >> FB;
    if (p > {64'd0, CAP}) begin
      sat = 1'b1;
      return CAP;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] kmul(logic [63:0] v, logic [63:0] k, inout bit sat);
    if (v > CAP / k) begin
      sat = 1'b1;
      return CAP;
    end
    return v * k;
  endfunction

  function automatic logic [31:0] force_axis(logic [63:0] ma, logic [63:0] mm, bit neg,
                                             logic [63:0] r2, inout bit sat);
    logic [127:0] q;
    logic [63:0]  lim, mag;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q = (ma * mm) / r2;
    mag = (q[127:64] != 0) ? CAP : q[63:0];
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? 32'(64'd0 - mag) : mag[31:0];
  endfunction

  function automatic res_t lj_predict(logic signed [31:0] p[6]);
    res_t r;
    logic signed [32:0] d[3];
    logic [63:0] mg[3], r2, x2, x6, x12, diff, e, t, g, m, w;
    logic [66:0] sum;
    logic signed [65:0] en;
    bit sat, eneg, gneg;
    r = '0;
    sat = 1'b0;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(p[i]) - 33'(p[i + 3]);
      mg[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
      sum += 67'(mg[i]) * 67'(mg[i]);
    end
    sum = sum >> FB;
    if (sum > {35'd0, cutoff_sq}) return r;
    r.inside_cutoff = 1'b1;
    if (sum == 0 && mg[0] == 0 && mg[1] == 0 && mg[2] == 0) begin
      r.zero_distance = 1'b1;
      return r;
    end
    r2 = (sum == 0) ? 64'd1 : sum[63:0];   // tiny separation rounds up to one LSB
    x2 = ({32'd0, sigma_sq} << FB) / r2;
    w = qmul(x2, x2, sat);
    x6 = qmul(w, x2, sat);
    x12 = qmul(x6, x6, sat);
    eneg = x12 < x6;
    diff = eneg ? x6 - x12 : x12 - x6;
    w = qmul({32'd0, well_depth}, diff, sat);
    e = kmul(w, 4, sat);
    if (e > ENERGY_LIMIT) e = ENERGY_LIMIT;
    en = (eneg ? -66'(e) : 66'(e)) - 66'(signed'(shift));
    if (en > 66'sd2147483647) begin
      en = 66'sd2147483647; sat = 1'b1;
    end
    if (en < -66'sd2147483648) begin
      en = -66'sd2147483648; sat = 1'b1;
    end
    r.pair_energy = en[31:0];
    t = kmul(x12, 2, sat);
    gneg = t < x6;
    g = gneg ? x6 - t : t - x6;
    w = qmul({32'd0, well_depth}, g, sat);
    m = kmul(w, 24, sat);
    r.force_x = force_axis(mg[0], m, ((d[0] < 0) != gneg) && mg[0] != 0 && m != 0, r2, sat);
    r.force_y = force_axis(mg[1], m, ((d[1] < 0) != gneg) && mg[1] != 0 && m != 0, r2, sat);
    r.force_z = force_axis(mg[2], m, ((d[2] < 0) != gneg) && mg[2] != 0 && m != 0, r2, sat);
    r.saturated = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SIGMA_SQ:     sigma_sq = val;
      REG_WELL_DEPTH:   well_depth = val;
      REG_CUTOFF_SQ:    cutoff_sq = val;
      REG_ENERGY_SHIFT: shift = val;
    endcase
  endtask

  // one pair transfer; valid stays high across back-to-back pairs
  task automatic send_pair(logic signed [31:0] p[6]);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.first_x <= p[0]; in_bus.first_y <= p[1]; in_bus.first_z <= p[2];
    in_bus.second_x <= p[3]; in_bus.second_y <= p[4]; in_bus.second_z <= p[5];
    do @(posedge clk); while (!in_bus.ready);
    expected_results.push_back(lj_predict(p));
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        res_t want, got;
        want = expected_results.pop_front();
        got.pair_energy = out_bus.pair_energy;
        got.force_x = out_bus.force_x;
        got.force_y = out_bus.force_y;
        got.force_z = out_bus.force_z;
        got.inside_cutoff = out_bus.inside_cutoff;
        got.saturated = out_bus.saturated;
        got.zero_distance = out_bus.zero_distance;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp E=%h F=%h/%h/%h in=%b sat=%b z=%b",
                      " got E=%h F=%h/%h/%h in=%b sat=%b z=%b"},
              want.pair_energy, want.force_x, want.force_y, want.force_z,
              want.inside_cutoff, want.saturated, want.zero_distance,
              got.pair_energy, got.force_x, got.force_y, got.force_z,
              got.inside_cutoff, got.saturated, got.zero_distance);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $signed(32'($urandom_range(65535) << $urandom_range(4))) -
                $signed(32'h0004_0000);
      default: return $signed(32'($urandom_range(32'h0008_0000))) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic send_random_pair();
    logic signed [31:0] p[6];
    for (int i = 0; i < 6; i++) p[i] = rand_coord();
    // most pairs sit a few units apart so the LJ terms stay in range
    if ($urandom_range(3) != 0)
      for (int i = 3; i < 6; i++)
        p[i] = p[i - 3] + $signed(32'($urandom_range(32'h0006_0000))) - 32'sh0003_0000;
    send_pair(p);
  endtask

  task automatic test_directed();
    logic signed [31:0] p[6];
    logic signed [31:0] ext[4] = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd0, -32'sd1};
    p = '{default: 0};
    send_pair(p);                                   // coincident particles
    p[0] = 32'sd1; send_pair(p);                    // tiny separation
    p[0] = 32'sh0001_0000; send_pair(p);            // r = sigma
    p[0] = 32'sh0001_1F5A; send_pair(p);            // near minimum
    p[0] = -32'sh0000_C000; send_pair(p);           // repulsive, negative axis
    p = '{32'sd0, 32'sh0003_0000, 32'sd0, 32'sd0, 32'sd0, -32'sh0001_0000};
    send_pair(p);
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++) begin
        p = '{ext[a], ext[b], ext[a], ext[b], ext[a], ext[b]};
        if (a + b < 6) send_pair(p);
      end
    drain();
  endtask

  task automatic test_config_sweep();
    reg_write(REG_CUTOFF_SQ, 32'h0004_0000);      // cutoff r = 2
    reg_write(REG_ENERGY_SHIFT, 32'hFFFF_F80C);   // small negative shift
    repeat (100) send_random_pair();
    drain();
    reg_write(REG_SIGMA_SQ, 32'hFFFF_FFFF);
    reg_write(REG_WELL_DEPTH, 32'hFFFF_FFFF);
    reg_write(REG_CUTOFF_SQ, 32'h0000_0000);
    reg_write(REG_ENERGY_SHIFT, 32'h7FFF_FFFF);
    repeat (100) send_random_pair();
    drain();
    reg_write(REG_CUTOFF_SQ, 32'hFFFF_FFFF);
    reg_write(REG_ENERGY_SHIFT, 32'h8000_0000);
    repeat (100) send_random_pair();
    drain();
    reg_write(REG_SIGMA_SQ, 32'h0000_0000);
    reg_write(REG_WELL_DEPTH, 32'h0000_0000);
    repeat (50) send_random_pair();
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        drain();
        reg_write(REG_SIGMA_SQ,
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000));
        reg_write(REG_WELL_DEPTH,
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000));
        reg_write(REG_CUTOFF_SQ, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom());
        reg_write(REG_ENERGY_SHIFT, $urandom_range(1) ? 32'd0 : $urandom());
      end
      send_random_pair();
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;      // sink stalls long; source keeps offering
    repeat (300) send_random_pair();
    drain();
  endtask

  initial begin
    sigma_sq = SIGMA_SQ_RST; well_depth = WELL_DEPTH_RST;
    cutoff_sq = CUTOFF_SQ_RST; shift = ENERGY_SHIFT_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 35; recv_idle_pct = 48;
    test_directed();
    test_config_sweep();
    test_random(400);
    send_idle_pct = 48; recv_idle_pct = 35;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(300);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
